// ----- rtl/ecal_pkg.sv -----
// Shared types, constants and the month-length function of the epoch
// seconds to calendar converter. No dependencies.
package ecal_pkg;

    localparam logic [17:0] DAY_SECS    = 18'd86400;
    localparam logic [17:0] ERA_DAYS    = 18'd146097;
    localparam logic [17:0] ERA_LAST    = 18'd146096;
    // floor(2^34 / divisor), used for the quotient digit estimates
    localparam logic [17:0] DAY_RECIP   = 18'd198841;
    localparam logic [17:0] ERA_RECIP   = 18'd117592;
    // 86399 plus the six-hour shift, used when the day count was negative
    localparam logic [17:0] TOD_NEG_BASE = 18'd107999;
    localparam logic [17:0] EPOCH_SHIFT = 18'd21600;
    localparam logic [16:0] TOD_SECS    = 17'd86400;
    localparam logic [16:0] HOUR_SECS   = 17'd3600;
    localparam logic [16:0] MIN_SECS    = 17'd60;
    // days from 0000-03-01 to 1945-08-15, proleptic Gregorian
    localparam int          EPOCH_DAY_FROM_MARCH0 = 710563;
    localparam logic [11:0] BASE_YEAR   = 12'd1945;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [8:0]  YOE_LAST    = 9'd399;
    localparam logic [6:0]  CENT_LAST   = 7'd99;
    // month index counts from March
    localparam logic [3:0]  MP_JAN      = 4'd10;
    localparam logic [3:0]  MP_FEB      = 4'd11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAY_START,
        ST_DAY_DIV,
        ST_TOD,
        ST_WRAP,
        ST_ERA_START,
        ST_ERA_DIV,
        ST_ERA,
        ST_YEAR,
        ST_MONTH,
        ST_HOUR,
        ST_MINUTE,
        ST_OUT
    } ecal_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_era;
        logic tod_set;
        logic tod_wrap;
        logic era_set;
        logic year_step;
        logic month_step;
        logic hour_step;
        logic minute_step;
    } ecal_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic year_more;
        logic month_more;
        logic hour_more;
        logic minute_more;
    } ecal_sts_t;

    // first member in the highest bits: year ends up lowest
    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } ecal_res_t;

    localparam int RES_W     = $bits(ecal_res_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    function automatic logic [4:0] month_days(input logic [3:0] mp, input logic leap);
        logic [4:0] len;
        unique case (mp)
            4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;  // Apr, Jun, Sep, Nov
            MP_FEB:                 len = leap ? 5'd29 : 5'd28;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar.sv -----
// Epoch seconds to calendar converter, top level: controller, datapath
// and output register. Uses ecal_pkg, ecal_ctrl, ecal_dp.
//
// Usage:
//   s_tdata carries a signed count of seconds from 1945-08-15 06:00. Each
//   accepted transaction gives exactly one m_ transaction with the year
//   offset from 1945, month, day, and hour/minute/second after the
//   six-hour shift.
//   One item is converted at a time. After acceptance the controller runs
//   the day and era divisions (16-bit digits from the top), then walks
//   one step per whole year inside the 400-year era (0..399), per whole
//   month (0..11), per whole hour (0..23) and per whole minute (0..59)
//   before the result is loaded into the output register.
//   s_tready is high only while the controller is idle, from the cycle after
//   the result is loaded; it stays high while a finished result waits.
//   If m_tready is low, the result holds in the output register; a second
//   conversion finishes its work and then waits for that register to free.
//   Reset (aresetn low, synchronous) returns to idle and empties the output.
module epoch_seconds_to_calendar #(
    parameter int unsigned SECONDS_BITS = 36
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [SECONDS_BITS-1:0] epoch_seconds, zero padded to whole bytes
    input  logic [((SECONDS_BITS + 7) / 8) * 8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // year_offset[11:0], month_number[15:12], day_of_month[20:16],
    // hour_of_day[25:21], minute_of_hour[31:26], second_of_minute[37:32]
    output logic [ecal_pkg::M_TDATA_W-1:0]         m_tdata
);
    import ecal_pkg::*;

    ecal_cmd_t             cmd;
    ecal_sts_t             sts;
    ecal_res_t             res;
    logic                  out_load;
    logic                  out_free;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    ecal_res_t             out_res;

    assign out_free = !m_tvalid_reg || m_tready;

    ecal_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .sts      (sts),
        .in_ready (s_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    ecal_dp #(.W(SECONDS_BITS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_secs (s_tdata[SECONDS_BITS-1:0]),
        .sts     (sts),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{(M_TDATA_W - RES_W){1'b0}}, res};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_res  = m_tdata_reg[RES_W-1:0];

    // one conversion at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a conversion is running");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_res.month >= 4'd1) && (out_res.month <= 4'd12)
                         && (out_res.day != 5'd0))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (out_res.hour <= 5'd23) && (out_res.minute <= 6'd59)
                         && (out_res.second <= 6'd59))
        else $error("time of day out of range");

endmodule

// ----- rtl/ecal_div.sv -----
// Divider by a constant of up to 18 bits: 16-bit dividend digits from the top,
// each quotient digit estimated by a reciprocal multiply and fixed by one
// compare and subtract. Depends on nothing.
module ecal_div #(
    parameter int unsigned W = 36
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [17:0]  divisor,
    // floor(2^34 / divisor)
    input  logic [17:0]  recip,
    output logic         busy,
    output logic [W-1:0] quotient,
    output logic [17:0]  remainder
);
    localparam int unsigned N_DIG = (W + 15) / 16;
    localparam int unsigned PAD_W = N_DIG * 16;
    localparam int          CNT_W = $clog2(N_DIG + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             fix_reg, fix_next;
    logic [PAD_W-1:0] num_reg, num_next;
    logic [PAD_W-1:0] quo_reg, quo_next;
    logic [17:0]      rem_reg, rem_next;
    logic [17:0]      dvs_reg, dvs_next;
    logic [17:0]      rcp_reg, rcp_next;
    logic [33:0]      part_reg, part_next;
    logic [15:0]      est_reg, est_next;
    logic [33:0]      part;
    logic [51:0]      est_prod;
    logic [33:0]      back_prod;
    logic [33:0]      diff;
    logic [18:0]      low_rem;
    logic             ge;

    always_comb begin
        // partial remainder is below the divisor, so the digit fits 16 bits
        part      = {rem_reg, num_reg[PAD_W-1 -: 16]};
        est_prod  = 52'(part) * 52'(rcp_reg);
        back_prod = 34'(est_reg) * 34'(dvs_reg);
        // estimate is low by at most one: remainder below twice the divisor
        diff      = part_reg - back_prod;
        low_rem   = diff[18:0];
        ge        = low_rem >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        fix_next  = fix_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rcp_next  = rcp_reg;
        part_next = part_reg;
        est_next  = est_reg;
        if (start) begin
            cnt_next = CNT_W'(N_DIG);
            fix_next = 1'b0;
            num_next = PAD_W'(dividend);
            quo_next = '0;
            rem_next = '0;
            dvs_next = divisor;
            rcp_next = recip;
        end else if (cnt_reg != '0) begin
            if (!fix_reg) begin
                part_next = part;
                est_next  = est_prod[49:34];
                num_next  = {num_reg[PAD_W-17:0], 16'h0000};
                fix_next  = 1'b1;
            end else begin
                quo_next = {quo_reg[PAD_W-17:0], est_reg + 16'(ge)};
                rem_next = ge ? 18'(low_rem - {1'b0, dvs_reg}) : low_rem[17:0];
                cnt_next = cnt_reg - 1'b1;
                fix_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            fix_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            fix_reg <= fix_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        rcp_reg  <= rcp_next;
        part_reg <= part_next;
        est_reg  <= est_next;
    end

    assign busy      = cnt_reg != '0;
    assign quotient  = quo_reg[W-1:0];
    assign remainder = rem_reg;

endmodule

// ----- rtl/ecal_dp.sv -----
// Datapath: floor divisions by day and by 400-year era, year and month
// walk inside the era, hour and minute split. Uses ecal_pkg and ecal_div.
module ecal_dp #(
    parameter int unsigned W = 36
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ecal_pkg::ecal_cmd_t  cmd,
    input  logic [W-1:0]         in_secs,
    output ecal_pkg::ecal_sts_t  sts,
    output ecal_pkg::ecal_res_t  res
);
    import ecal_pkg::*;

    logic [W-1:0]  secs_reg;
    logic          neg_reg;
    logic [W-1:0]  days_reg;
    logic [16:0]   tod_reg;
    logic [11:0]   era400_reg;
    logic [17:0]   doe_reg;
    logic [8:0]    yoe_reg;
    logic [1:0]    c4_reg;
    logic [6:0]    c100_reg;
    logic [3:0]    mp_reg;
    logic [4:0]    hour_reg;
    logic [5:0]    minute_reg;

    logic [W-1:0]  z;
    logic [W-1:0]  src;
    logic          src_neg;
    logic [W-1:0]  mag;
    logic [17:0]   dvs;
    logic [17:0]   rcp;
    logic          div_busy;
    logic [W-1:0]  quotient;
    logic [17:0]   remainder;
    logic [W-1:0]  q_fix;
    logic [20:0]   era_prod;
    logic          leap;
    logic [8:0]    year_len;
    logic [4:0]    month_len;

    always_comb begin
        z       = days_reg + W'(EPOCH_DAY_FROM_MARCH0);
        src     = cmd.div_era ? z : secs_reg;
        src_neg = src[W-1];
        // floor division of a negative x goes through -x-1
        mag     = src_neg ? ~src : src;
        dvs     = cmd.div_era ? ERA_DAYS : DAY_SECS;
        rcp     = cmd.div_era ? ERA_RECIP : DAY_RECIP;
        q_fix   = neg_reg ? ~quotient : quotient;
        era_prod = 21'(q_fix[11:0]) * 21'd400;
        // year yoe of the era covers March of yoe .. February of yoe+1, c4/c100 track yoe+1
        leap      = (c4_reg == 2'd0) && ((c100_reg != 7'd0) || (yoe_reg == YOE_LAST));
        year_len  = YEAR_DAYS + 9'(leap);
        month_len = month_days(mp_reg, leap);
    end

    ecal_div #(.W(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (mag),
        .divisor   (dvs),
        .recip     (rcp),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            secs_reg <= in_secs;
        end
        if (cmd.div_start) begin
            neg_reg <= src_neg;
        end
        if (cmd.tod_set) begin
            days_reg   <= q_fix;
            tod_reg    <= neg_reg ? 17'(TOD_NEG_BASE - remainder)
                                  : 17'(remainder + EPOCH_SHIFT);
            hour_reg   <= '0;
            minute_reg <= '0;
        end
        if (cmd.tod_wrap && (tod_reg >= TOD_SECS)) begin
            tod_reg  <= tod_reg - TOD_SECS;
            days_reg <= days_reg + 1'b1;
        end
        if (cmd.era_set) begin
            era400_reg <= era_prod[11:0];
            doe_reg    <= neg_reg ? (ERA_LAST - remainder) : remainder;
            yoe_reg    <= '0;
            c4_reg     <= 2'd1;
            c100_reg   <= 7'd1;
            mp_reg     <= '0;
        end
        if (cmd.year_step) begin
            doe_reg  <= doe_reg - 18'(year_len);
            yoe_reg  <= yoe_reg + 1'b1;
            c4_reg   <= c4_reg + 1'b1;
            c100_reg <= (c100_reg == CENT_LAST) ? 7'd0 : c100_reg + 1'b1;
        end
        if (cmd.month_step) begin
            doe_reg <= doe_reg - 18'(month_len);
            mp_reg  <= mp_reg + 1'b1;
        end
        if (cmd.hour_step) begin
            tod_reg  <= tod_reg - HOUR_SECS;
            hour_reg <= hour_reg + 1'b1;
        end
        if (cmd.minute_step) begin
            tod_reg    <= tod_reg - MIN_SECS;
            minute_reg <= minute_reg + 1'b1;
        end
    end

    always_comb begin
        sts.div_busy    = div_busy;
        sts.year_more   = doe_reg >= 18'(year_len);
        sts.month_more  = doe_reg >= 18'(month_len);
        sts.hour_more   = tod_reg >= HOUR_SECS;
        sts.minute_more = tod_reg >= MIN_SECS;

        res.year   = era400_reg + 12'(yoe_reg) + 12'(mp_reg >= MP_JAN) - BASE_YEAR;
        res.month  = (mp_reg < MP_JAN) ? mp_reg + 4'd3 : mp_reg - 4'd9;
        res.day    = doe_reg[4:0] + 5'd1;
        res.hour   = hour_reg;
        res.minute = minute_reg;
        res.second = tod_reg[5:0];
    end

endmodule

// ----- rtl/ecal_ctrl.sv -----
// Controller state machine: sequences the two divisions, the year,
// month, hour and minute walks and the result hand-off. Uses ecal_pkg.
module ecal_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 out_free,
    input  ecal_pkg::ecal_sts_t  sts,
    output logic                 in_ready,
    output logic                 out_load,
    output ecal_pkg::ecal_cmd_t  cmd
);
    import ecal_pkg::*;

    ecal_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DAY_START;
                end
            end
            ST_DAY_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DAY_DIV;
            end
            ST_DAY_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_TOD;
                end
            end
            ST_TOD: begin
                cmd.tod_set = 1'b1;
                state_next  = ST_WRAP;
            end
            ST_WRAP: begin
                cmd.tod_wrap = 1'b1;
                state_next   = ST_ERA_START;
            end
            ST_ERA_START: begin
                cmd.div_start = 1'b1;
                cmd.div_era   = 1'b1;
                state_next    = ST_ERA_DIV;
            end
            ST_ERA_DIV: begin
                if (!sts.div_busy) begin
                    state_next = ST_ERA;
                end
            end
            ST_ERA: begin
                cmd.era_set = 1'b1;
                state_next  = ST_YEAR;
            end
            ST_YEAR: begin
                if (sts.year_more) begin
                    cmd.year_step = 1'b1;
                end else begin
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH: begin
                if (sts.month_more) begin
                    cmd.month_step = 1'b1;
                end else begin
                    state_next = ST_HOUR;
                end
            end
            ST_HOUR: begin
                if (sts.hour_more) begin
                    cmd.hour_step = 1'b1;
                end else begin
                    state_next = ST_MINUTE;
                end
            end
            ST_MINUTE: begin
                if (sts.minute_more) begin
                    cmd.minute_step = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for epoch_seconds_to_calendar: drives signed epoch
// seconds on the s_ stream and checks every m_ result against a date predictor.
// Depends on rtl/ecal_pkg.sv and rtl/epoch_seconds_to_calendar.sv.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecal_pkg::*;

    localparam int SECS_W         = 36;
    localparam int S_TDATA_W      = ((SECS_W + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4 * ((SECS_W + 15) / 16) + 520;
    localparam longint SECS_PER_DAY = 86400;
    localparam longint SHIFT_SECS   = 6 * 3600;

    class calendar_scoreboard;
        ecal_res_t   due_dates[$];
        int unsigned errors;

        static function ecal_res_t calendar_of(logic [SECS_W-1:0] raw);
            longint    secs, days, tod, z, era, doe, yoe, doy, mp, d, m, y;
            ecal_res_t r;
            secs = $signed(raw);
            days = secs / SECS_PER_DAY;
            tod  = secs % SECS_PER_DAY;
            if (tod < 0) begin
                tod  += SECS_PER_DAY;
                days -= 1;
            end
            tod += SHIFT_SECS;
            if (tod >= SECS_PER_DAY) begin
                tod  -= SECS_PER_DAY;
                days += 1;
            end
            // civil date from a day count based at 0000-03-01
            z   = days + 710563;
            era = (z >= 0 ? z : z - 146096) / 146097;
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            d   = doy - (153 * mp + 2) / 5 + 1;
            m   = mp < 10 ? mp + 3 : mp - 9;
            y   = yoe + era * 400 + (m <= 2 ? 1 : 0);
            r.year   = 12'(y - 1945);
            r.month  = 4'(m);
            r.day    = 5'(d);
            r.hour   = 5'(tod / 3600);
            r.minute = 6'((tod % 3600) / 60);
            r.second = 6'(tod % 60);
            return r;
        endfunction

        function void note_input(logic [S_TDATA_W-1:0] data);
            due_dates = {due_dates, calendar_of(data[SECS_W-1:0])};
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            ecal_res_t got, want;
            got = ecal_res_t'(data[RES_W-1:0]);
            if (due_dates.size() == 0) begin
                $error("unexpected result transaction: %h", data);
                errors++;
                return;
            end
            want = due_dates.pop_front();
            if (got.year != want.year) begin
                $error("year_offset: expected %0d, got %0d", $signed(want.year),
                       $signed(got.year));
                errors++;
            end
            if (got.month != want.month) begin
                $error("month_number: expected %0d, got %0d", want.month, got.month);
                errors++;
            end
            if (got.day != want.day) begin
                $error("day_of_month: expected %0d, got %0d", want.day, got.day);
                errors++;
            end
            if (got.hour != want.hour) begin
                $error("hour_of_day: expected %0d, got %0d", want.hour, got.hour);
                errors++;
            end
            if (got.minute != want.minute) begin
                $error("minute_of_hour: expected %0d, got %0d", want.minute, got.minute);
                errors++;
            end
            if (got.second != want.second) begin
                $error("second_of_minute: expected %0d, got %0d", want.second,
                       got.second);
                errors++;
            end
        endfunction

        function int pending();
            return due_dates.size();
        endfunction
    endclass

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    calendar_scoreboard sb = new;
    bit                 no_idle = 1'b0;
    int unsigned        quiet_cycles = 0;

    // day numbers (day 0 = 1945-08-15) at leap, century and era edges
    longint edge_days[9] = '{0, 19921, 19922, -16604, -16603, 56446, -126175,
                             166019, -272272};

    always #10 aclk = ~aclk;

    epoch_seconds_to_calendar #(.SECONDS_BITS(SECS_W)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // result checking and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_result(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // receiver: random stall before each result transaction
    initial begin
        int unsigned stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_secs(longint secs, bit pad_random);
        logic [S_TDATA_W-1:0] data;
        data = '0;
        data[SECS_W-1:0] = secs[SECS_W-1:0];
        // bits above the field are don't-care for the block
        if (pad_random) begin
            data[S_TDATA_W-1:SECS_W] = (S_TDATA_W - SECS_W)'($urandom);
        end
        return data;
    endfunction

    // seconds value that lands on the given day and shifted time of day
    function automatic longint day_secs(longint day_num, longint tod);
        return day_num * SECS_PER_DAY + tod - SHIFT_SECS;
    endfunction

    task automatic send_seconds(logic [S_TDATA_W-1:0] data);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(data);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        longint secs;
        longint max_secs, min_secs;
        int     pick;
        max_secs = (longint'(1) << (SECS_W - 1)) - 1;
        min_secs = -(longint'(1) << (SECS_W - 1));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, day and hour edges, leap and era edges
        send_seconds(pack_secs(0, 0));
        send_seconds(pack_secs(1, 0));
        send_seconds(pack_secs(-1, 0));
        send_seconds(pack_secs(max_secs, 0));
        send_seconds(pack_secs(min_secs, 0));
        send_seconds({{(S_TDATA_W - SECS_W){1'b1}}, SECS_W'(0)});
        send_seconds(pack_secs(-SHIFT_SECS, 0));
        send_seconds(pack_secs(-SHIFT_SECS - 1, 0));
        send_seconds(pack_secs(SECS_PER_DAY - SHIFT_SECS - 1, 0));
        send_seconds(pack_secs(SECS_PER_DAY - SHIFT_SECS, 0));
        send_seconds(pack_secs(-SECS_PER_DAY, 0));
        send_seconds(pack_secs(-SECS_PER_DAY - 1, 0));
        send_seconds(pack_secs(3599, 0));
        send_seconds(pack_secs(day_secs(19921, 43200), 0));
        send_seconds(pack_secs(day_secs(19922, 0) - 1, 0));
        send_seconds(pack_secs(day_secs(-16604, 86399), 0));
        send_seconds(pack_secs(day_secs(-16603, 0), 0));
        send_seconds(pack_secs(day_secs(56446, 0) - 1, 0));
        send_seconds(pack_secs(day_secs(-126175, 0), 0));
        send_seconds(pack_secs(day_secs(-126175, 0) - 1, 0));
        send_seconds(pack_secs(day_secs(166019, 3661), 0));
        send_seconds(pack_secs(day_secs(-272272, 0) - 1, 0));

        // hold the sender until the block is empty
        drain_results();

        for (int i = 0; i < 100; i++) begin
            no_idle = (i < 30);
            if (i == 60) begin
                drain_results();
            end
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                secs = $signed({$urandom, $urandom}) >>> (64 - SECS_W);
            end else if (pick < 7) begin
                secs = day_secs(edge_days[$urandom_range(0, 8)]
                                + longint'($urandom_range(0, 6)) - 3,
                                $urandom_range(0, 86399));
            end else begin
                secs = longint'($urandom_range(0, 200000000)) - 100000000;
            end
            send_seconds(pack_secs(secs, 1));
        end
        no_idle = 1'b0;

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ecal_pkg.sv
rtl/ecal_div.sv
rtl/ecal_dp.sv
rtl/ecal_ctrl.sv
rtl/epoch_seconds_to_calendar.sv
tb/tb.sv
